/* design/pss_pkg.sv */
// ----------------------------------------------------------------------------
// pss_pkg: shared definitions for the positional sequence store
// Sizes, operation codes and derived widths used by the store and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

	localparam int DEPTH   = 64;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int POS_W   = 7;
	localparam int DATA_W  = 32;
	localparam int OP_W    = 3;
	localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND      = 3'd0,
		OP_INSERT      = 3'd1,
		OP_DELETE_AT   = 3'd2,
		OP_DELETE_LAST = 3'd3,
		OP_READ        = 3'd4,
		OP_OVERWRITE   = 3'd5,
		OP_CLEAR       = 3'd6
	} op_t;

endpackage

`default_nettype wire

/* design/positional_sequence_store.sv */
// ----------------------------------------------------------------------------
// positional_sequence_store: ordered store of signed words with insert/delete
// One-based positional list held in a single-port-per-direction memory; a
// small sequencer moves entries one at a time for insert and delete.
// ----------------------------------------------------------------------------
//  channel   signals                          handshake
//  request   op, position, value              taken when start && !busy
//  result    ok, read_value, count            valid for one cycle on done
//
//  Insert before position p moves entries p to count up one place and delete
//  at p moves the entries after p down one place, one entry at a time; each
//  moved entry costs one memory read and one write.
//  Reset clears the count and the sequencer; memory contents are not cleared.
//  The receiver cannot stall: done pulses once per item with its result.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_sequence_store (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [pss_pkg::OP_W-1:0]            op,
	input  wire logic [pss_pkg::POS_W-1:0]           position,
	input  wire logic signed [pss_pkg::DATA_W-1:0]   value,
	output logic                                     done,
	output logic                                     ok,
	output logic signed [pss_pkg::DATA_W-1:0]        read_value,
	output logic [pss_pkg::CNT_W-1:0]                count
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_INS_FIN,
		ST_READ_WAIT
	} state_t;

	state_t                              state_q;
	pss_pkg::op_t                        op_q;
	logic [pss_pkg::POS_W-1:0]           pos_q;
	logic [pss_pkg::DATA_W-1:0]          val_q;
	logic [pss_pkg::CNT_W-1:0]           cnt_q;
	logic [pss_pkg::ADDR_W-1:0]          ptr_q;
	logic                                done_q;
	logic                                ok_q;
	logic [pss_pkg::DATA_W-1:0]          rval_q;

	logic [pss_pkg::DATA_W-1:0]          mem [pss_pkg::DEPTH];
	logic [pss_pkg::DATA_W-1:0]          mem_rdata_q;

	logic                                mem_we;
	logic [pss_pkg::ADDR_W-1:0]          mem_waddr;
	logic [pss_pkg::DATA_W-1:0]          mem_wdata;
	logic [pss_pkg::ADDR_W-1:0]          mem_raddr;

	logic [pss_pkg::CMP_W-1:0]           pos_ext;
	logic [pss_pkg::CMP_W-1:0]           cnt_ext;
	logic                                pos_ok;
	logic                                full;
	logic [pss_pkg::ADDR_W-1:0]          pos_idx;
	logic [pss_pkg::ADDR_W-1:0]          cnt_idx;
	logic [pss_pkg::ADDR_W-1:0]          last_idx;

	assign pos_ext  = pss_pkg::CMP_W'(pos_q);
	assign cnt_ext  = pss_pkg::CMP_W'(cnt_q);
	assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
	assign full     = (cnt_q == pss_pkg::CNT_W'(pss_pkg::DEPTH));
	assign pos_idx  = pss_pkg::ADDR_W'(pos_q - pss_pkg::POS_W'(1));
	assign cnt_idx  = pss_pkg::ADDR_W'(cnt_q);
	assign last_idx = pss_pkg::ADDR_W'(cnt_q - pss_pkg::CNT_W'(1));

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_idx;
		mem_wdata = val_q;
		mem_raddr = (state_q == ST_SHIFT_RD) ? ptr_q : pos_idx;
		unique case (state_q)
			ST_EXEC: begin
				if (op_q == pss_pkg::OP_APPEND && !full) begin
					mem_we    = 1'b1;
					mem_waddr = cnt_idx;
				end else if (op_q == pss_pkg::OP_OVERWRITE && pos_ok) begin
					mem_we    = 1'b1;
					mem_waddr = pos_idx;
				end
			end
			ST_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata_q;
				mem_waddr = (op_q == pss_pkg::OP_INSERT) ? ptr_q + pss_pkg::ADDR_W'(1)
				                                         : ptr_q - pss_pkg::ADDR_W'(1);
			end
			ST_INS_FIN: begin
				mem_we    = 1'b1;
				mem_waddr = pos_idx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= pss_pkg::OP_APPEND;
			pos_q   <= '0;
			val_q   <= '0;
			cnt_q   <= '0;
			ptr_q   <= '0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			rval_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q    <= pss_pkg::op_t'(op);
						pos_q   <= position;
						val_q   <= value;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
					ok_q    <= 1'b0;
					rval_q  <= '0;
					case (op_q)
						pss_pkg::OP_APPEND: begin
							if (!full) begin
								cnt_q <= cnt_q + pss_pkg::CNT_W'(1);
								ok_q  <= 1'b1;
							end
						end
						pss_pkg::OP_INSERT: begin
							if (pos_ok && !full) begin
								ptr_q   <= last_idx;
								state_q <= ST_SHIFT_RD;
								done_q  <= 1'b0;
							end
						end
						pss_pkg::OP_DELETE_AT: begin
							if (pos_ok) begin
								if (pos_ext == cnt_ext) begin
									cnt_q <= cnt_q - pss_pkg::CNT_W'(1);
									ok_q  <= 1'b1;
								end else begin
									ptr_q   <= pss_pkg::ADDR_W'(pos_q);
									state_q <= ST_SHIFT_RD;
									done_q  <= 1'b0;
								end
							end
						end
						pss_pkg::OP_DELETE_LAST: begin
							if (cnt_q != '0) begin
								cnt_q <= cnt_q - pss_pkg::CNT_W'(1);
								ok_q  <= 1'b1;
							end
						end
						pss_pkg::OP_READ: begin
							if (pos_ok) begin
								state_q <= ST_READ_WAIT;
								done_q  <= 1'b0;
							end
						end
						pss_pkg::OP_OVERWRITE: begin
							ok_q <= pos_ok;
						end
						pss_pkg::OP_CLEAR: begin
							cnt_q <= '0;
							ok_q  <= 1'b1;
						end
						default: begin
						end
					endcase
				end
				ST_SHIFT_RD: begin
					state_q <= ST_SHIFT_WR;
				end
				ST_SHIFT_WR: begin
					if (op_q == pss_pkg::OP_INSERT) begin
						if (ptr_q == pos_idx) begin
							state_q <= ST_INS_FIN;
						end else begin
							ptr_q   <= ptr_q - pss_pkg::ADDR_W'(1);
							state_q <= ST_SHIFT_RD;
						end
					end else begin
						if (ptr_q == last_idx) begin
							cnt_q   <= cnt_q - pss_pkg::CNT_W'(1);
							ok_q    <= 1'b1;
							done_q  <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							ptr_q   <= ptr_q + pss_pkg::ADDR_W'(1);
							state_q <= ST_SHIFT_RD;
						end
					end
				end
				ST_INS_FIN: begin
					cnt_q   <= cnt_q + pss_pkg::CNT_W'(1);
					ok_q    <= 1'b1;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_READ_WAIT: begin
					rval_q  <= mem_rdata_q;
					ok_q    <= 1'b1;
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign ok         = ok_q;
	assign read_value = rval_q;
	assign count      = cnt_q;

endmodule

`default_nettype wire

/* design/pss_checker.sv */
// ----------------------------------------------------------------------------
// pss_checker: port-level checks for the positional sequence store
// Watches the request and result ports and flags sequencing slips.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                start,
	input wire logic                                busy,
	input wire logic                                done,
	input wire logic                                ok,
	input wire logic signed [pss_pkg::DATA_W-1:0]   read_value,
	input wire logic [pss_pkg::CNT_W-1:0]           count
);

	// The block is busy in the cycle after it accepts an item.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// No result appears in the cycle right after an item is accepted.
	a_no_early_done: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobe too soon after acceptance");

	// A result is presented only once the sequencer is back to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	// A failed request never returns data.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ok |-> read_value == '0)
		else $error("nonzero read value on a failed request");

	// The count never exceeds the store depth when a result is presented.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count <= pss_pkg::CNT_W'(pss_pkg::DEPTH))
		else $error("count beyond store depth");

endmodule

bind positional_sequence_store pss_checker u_pss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.ok         (ok),
	.read_value (read_value),
	.count      (count)
);

`default_nettype wire
